### src/playfair_digraph_cipher_core_assert.svh
// assertion macros for the playfair digraph cipher core
// expects clk and rst_n in the scope of each use
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfc assertion failed");
`define PFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfc assertion failed");
`else
`define PFC_ASSERT_IMP(lbl, ante, cons)
`define PFC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/pfc_pkg.sv
// shared types, constants and helpers for the playfair digraph cipher core
// no dependencies
package pfc_pkg;

  localparam int unsigned AlphaSize   = 26;
  localparam int unsigned SquareCells = 25;
  localparam int unsigned SquareSide  = 5;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;
  typedef logic [2:0] opcode_t;

  localparam letter_t LetI = letter_t'(8);
  localparam letter_t LetJ = letter_t'(9);
  localparam letter_t LetQ = letter_t'(16);
  localparam letter_t LetX = letter_t'(23);
  localparam letter_t LastLetter = letter_t'(AlphaSize - 1);
  localparam cell_t   FullCount  = cell_t'(SquareCells);
  localparam coord_t  LastCoord  = coord_t'(SquareSide - 1);

  typedef enum logic [2:0] {
    OP_START_KEY  = 3'd0,
    OP_KEY_LETTER = 3'd1,
    OP_FINISH_KEY = 3'd2,
    OP_PLAIN      = 3'd3,
    OP_END_MSG    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_B,
    ST_RULE,
    ST_SQ_A,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

  // row and column of a letter in the square
  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    logic    clear;
    logic    place_en;
    letter_t place_let;
    logic    pos_rd_en;
    letter_t pos_rd_let;
    logic    sq_rd_en;
    cell_t   sq_rd_cell;
  } sq_req_t;

  typedef struct packed {
    logic    full;
    pos_t    pos_q;
    letter_t sq_q;
  } sq_rsp_t;

  function automatic coord_t inc_coord(coord_t c);
    return (c == LastCoord) ? coord_t'(0) : coord_t'(c + coord_t'(1));
  endfunction

  function automatic cell_t cell_index(coord_t r, coord_t c);
    return cell_t'({r, 2'b00}) + cell_t'({2'b00, r}) + cell_t'({2'b00, c});
  endfunction

  function automatic letter_t fold_j(letter_t l);
    return (l == LetJ) ? LetI : l;
  endfunction

  function automatic letter_t filler_for(letter_t l);
    return (l == LetX) ? LetQ : LetX;
  endfunction

endpackage

### src/pfc_in_if.sv
// input item channel of the playfair digraph cipher core
// depends on pfc_pkg
interface pfc_in_if;
  logic                valid;
  logic                ready;
  pfc_pkg::opcode_t    operation;
  pfc_pkg::letter_t    letter;

  modport source (output valid, output operation, output letter, input ready);
  modport sink   (input valid, input operation, input letter, output ready);
endinterface

### src/pfc_out_if.sv
// result item channel of the playfair digraph cipher core
// depends on pfc_pkg
interface pfc_out_if;
  logic                valid;
  logic                ready;
  pfc_pkg::letter_t    cipher_letter;
  logic                pair_end;

  modport source (output valid, output cipher_letter, output pair_end, input ready);
  modport sink   (input valid, input cipher_letter, input pair_end, output ready);
endinterface

### src/pfc_square.sv
// key square storage: cell memory, letter position memory, used mask, fill count
// depends on pfc_pkg
module pfc_square (
  input  logic              clk,
  input  logic              rst_n,
  input  pfc_pkg::sq_req_t  req,
  output pfc_pkg::sq_rsp_t  rsp
);

  pfc_pkg::letter_t sq_mem  [pfc_pkg::SquareCells];
  pfc_pkg::pos_t    pos_mem [pfc_pkg::AlphaSize];

  logic [pfc_pkg::AlphaSize-1:0] used_r, used_nxt;
  pfc_pkg::cell_t   fill_cnt_r, fill_cnt_nxt;
  pfc_pkg::coord_t  fill_row_r, fill_row_nxt;
  pfc_pkg::coord_t  fill_col_r, fill_col_nxt;
  pfc_pkg::pos_t    pos_q_r;
  pfc_pkg::letter_t sq_q_r;

  logic full;
  logic let_ok;
  logic let_used;
  logic place_ok;

  assign full     = (fill_cnt_r == pfc_pkg::FullCount);
  assign let_ok   = (req.place_let < pfc_pkg::letter_t'(pfc_pkg::AlphaSize));
  assign let_used = let_ok ? used_r[req.place_let] : 1'b1;
  assign place_ok = req.place_en && let_ok && !let_used && !full;

  always_comb begin
    used_nxt     = used_r;
    fill_cnt_nxt = fill_cnt_r;
    fill_row_nxt = fill_row_r;
    fill_col_nxt = fill_col_r;
    if (req.clear) begin
      used_nxt     = '0;
      fill_cnt_nxt = '0;
      fill_row_nxt = '0;
      fill_col_nxt = '0;
    end else if (place_ok) begin
      used_nxt[req.place_let] = 1'b1;
      fill_cnt_nxt = pfc_pkg::cell_t'(fill_cnt_r + pfc_pkg::cell_t'(1));
      // next cell in row-major order
      if (fill_col_r == pfc_pkg::LastCoord) begin
        fill_col_nxt = '0;
        fill_row_nxt = pfc_pkg::coord_t'(fill_row_r + pfc_pkg::coord_t'(1));
      end else begin
        fill_col_nxt = pfc_pkg::coord_t'(fill_col_r + pfc_pkg::coord_t'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      fill_cnt_r <= '0;
      fill_row_r <= '0;
      fill_col_r <= '0;
    end else begin
      used_r     <= used_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      fill_row_r <= fill_row_nxt;
      fill_col_r <= fill_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (place_ok && !req.clear) begin
      sq_mem[fill_cnt_r]     <= req.place_let;
      pos_mem[req.place_let] <= '{row: fill_row_r, col: fill_col_r};
    end
    if (req.pos_rd_en) begin
      pos_q_r <= pos_mem[req.pos_rd_let];
    end
    if (req.sq_rd_en) begin
      sq_q_r <= sq_mem[req.sq_rd_cell];
    end
  end

  assign rsp.full  = full;
  assign rsp.pos_q = pos_q_r;
  assign rsp.sq_q  = sq_q_r;

endmodule

### src/pfc_rule.sv
// digraph rule unit: same column, same row or rectangle, gives the two target cells
// depends on pfc_pkg
module pfc_rule (
  input  pfc_pkg::pos_t  pa,
  input  pfc_pkg::pos_t  pb,
  output pfc_pkg::cell_t na,
  output pfc_pkg::cell_t nb
);

  always_comb begin
    if (pa.col == pb.col) begin
      na = pfc_pkg::cell_index(pfc_pkg::inc_coord(pa.row), pa.col);
      nb = pfc_pkg::cell_index(pfc_pkg::inc_coord(pb.row), pb.col);
    end else if (pa.row == pb.row) begin
      na = pfc_pkg::cell_index(pa.row, pfc_pkg::inc_coord(pa.col));
      nb = pfc_pkg::cell_index(pb.row, pfc_pkg::inc_coord(pb.col));
    end else begin
      na = pfc_pkg::cell_index(pa.row, pb.col);
      nb = pfc_pkg::cell_index(pb.row, pa.col);
    end
  end

endmodule

### src/playfair_digraph_cipher_core.sv
// playfair digraph cipher core, top level with the item sequencer
// depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_square, pfc_rule and the assert header
//
// usage:
//   in_ch carries one item per handshake: an operation code and a letter (A=0..Z=25).
//   a key is loaded as start key, key letters, finish key; plaintext letters follow
//   and end of message flushes an odd last letter padded with X (Q after an X).
//   out_ch gives cipher letters two per pair, pair_end high on the second one.
// sequencing:
//   start key, key letter, a plaintext letter that only waits for its partner, an
//   ignored item: ready again in the next cycle.
//   finish key: the fill sweep takes one alphabet letter per cycle, placing it
//   unless it is J or already used; in_ch is not ready until the sweep ends.
//   an item that completes a pair: two position reads and two cell reads, all on
//   the single read port of each key memory, via POS_B, RULE (registers results),
//   SQ_A, EMIT_A (first letter to out_ch) and EMIT_B (second letter, pair_end).
// reset: rst_n (synchronous) empties the square and drops any waiting letter; the
//   memories keep old contents, which are never read before a new key fills them.
// stall: a low out_ready freezes the sequencer in its emit state; the output
//   register keeps the letter, and a new item is taken while the last letter waits.
`include "playfair_digraph_cipher_core_assert.svh"

module playfair_digraph_cipher_core (
  input  logic             clk,
  input  logic             rst_n,
  pfc_in_if.sink           in_ch,
  pfc_out_if.source        out_ch
);

  pfc_pkg::state_t  state_r, state_nxt;
  pfc_pkg::sq_req_t sq_req;
  pfc_pkg::sq_rsp_t sq_rsp;

  // waiting plaintext letter
  logic             pend_valid_r, pend_valid_nxt;
  pfc_pkg::letter_t pend_let_r, pend_let_nxt;

  // pair operands and rule results
  pfc_pkg::letter_t b_let_r, b_let_nxt;
  pfc_pkg::pos_t    pa_r, pa_nxt;
  pfc_pkg::cell_t   na_r, na_nxt;
  pfc_pkg::cell_t   nb_r, nb_nxt;
  pfc_pkg::cell_t   rule_na, rule_nb;

  // fill sweep letter
  pfc_pkg::letter_t sweep_r, sweep_nxt;
  logic             sweep_last;

  // output register
  logic             out_valid_r, out_valid_nxt;
  pfc_pkg::letter_t out_let_r, out_let_nxt;
  logic             out_end_r, out_end_nxt;
  logic             out_free;
  logic             out_load;

  logic             in_fire;
  pfc_pkg::letter_t in_let;
  logic             in_let_ok;

  assign in_fire    = in_ch.valid && (state_r == pfc_pkg::ST_IDLE);
  assign in_let     = pfc_pkg::fold_j(in_ch.letter);
  assign in_let_ok  = (in_let < pfc_pkg::letter_t'(pfc_pkg::AlphaSize));
  assign out_free   = !out_valid_r || out_ch.ready;
  assign sweep_last = (state_r == pfc_pkg::ST_FILL) && (sweep_r == pfc_pkg::LastLetter);

  pfc_square u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  pfc_rule u_rule (
    .pa (pa_r),
    .pb (sq_rsp.pos_q),
    .na (rule_na),
    .nb (rule_nb)
  );

  // sequencer: next state, memory requests, pending letter and output loads
  always_comb begin
    state_nxt      = state_r;
    sq_req         = '0;
    pend_valid_nxt = pend_valid_r;
    pend_let_nxt   = pend_let_r;
    b_let_nxt      = b_let_r;
    pa_nxt         = pa_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    sweep_nxt      = sweep_r;
    out_load       = 1'b0;
    out_let_nxt    = out_let_r;
    out_end_nxt    = out_end_r;

    unique case (state_r)
      pfc_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.operation)
            pfc_pkg::OP_START_KEY: begin
              sq_req.clear   = 1'b1;
              pend_valid_nxt = 1'b0;
              pend_let_nxt   = '0;
            end
            pfc_pkg::OP_KEY_LETTER: begin
              sq_req.place_en  = 1'b1;
              sq_req.place_let = in_let;
            end
            pfc_pkg::OP_FINISH_KEY: begin
              sweep_nxt = '0;
              state_nxt = pfc_pkg::ST_FILL;
            end
            pfc_pkg::OP_PLAIN: begin
              if (in_let_ok && sq_rsp.full) begin
                if (!pend_valid_r) begin
                  pend_valid_nxt = 1'b1;
                  pend_let_nxt   = in_let;
                end else if (pend_let_r == in_let) begin
                  // doubled letter: pair with a filler, the letter keeps waiting
                  sq_req.pos_rd_en  = 1'b1;
                  sq_req.pos_rd_let = in_let;
                  b_let_nxt         = pfc_pkg::filler_for(in_let);
                  state_nxt         = pfc_pkg::ST_POS_B;
                end else begin
                  sq_req.pos_rd_en  = 1'b1;
                  sq_req.pos_rd_let = pend_let_r;
                  b_let_nxt         = in_let;
                  pend_valid_nxt    = 1'b0;
                  state_nxt         = pfc_pkg::ST_POS_B;
                end
              end
            end
            pfc_pkg::OP_END_MSG: begin
              if (pend_valid_r && sq_rsp.full) begin
                sq_req.pos_rd_en  = 1'b1;
                sq_req.pos_rd_let = pend_let_r;
                b_let_nxt         = pfc_pkg::filler_for(pend_let_r);
                pend_valid_nxt    = 1'b0;
                state_nxt         = pfc_pkg::ST_POS_B;
              end
            end
            default: begin
              // unused operation codes are dropped
            end
          endcase
        end
      end
      pfc_pkg::ST_FILL: begin
        // J never enters the square
        sq_req.place_en  = (sweep_r != pfc_pkg::LetJ);
        sq_req.place_let = sweep_r;
        if (sweep_r == pfc_pkg::LastLetter) begin
          state_nxt = pfc_pkg::ST_IDLE;
        end else begin
          sweep_nxt = pfc_pkg::letter_t'(sweep_r + pfc_pkg::letter_t'(1));
        end
      end
      pfc_pkg::ST_POS_B: begin
        pa_nxt            = sq_rsp.pos_q;
        sq_req.pos_rd_en  = 1'b1;
        sq_req.pos_rd_let = b_let_r;
        state_nxt         = pfc_pkg::ST_RULE;
      end
      pfc_pkg::ST_RULE: begin
        na_nxt    = rule_na;
        nb_nxt    = rule_nb;
        state_nxt = pfc_pkg::ST_SQ_A;
      end
      pfc_pkg::ST_SQ_A: begin
        sq_req.sq_rd_en   = 1'b1;
        sq_req.sq_rd_cell = na_r;
        state_nxt         = pfc_pkg::ST_EMIT_A;
      end
      pfc_pkg::ST_EMIT_A: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_let_nxt       = sq_rsp.sq_q;
          out_end_nxt       = 1'b0;
          sq_req.sq_rd_en   = 1'b1;
          sq_req.sq_rd_cell = nb_r;
          state_nxt         = pfc_pkg::ST_EMIT_B;
        end
      end
      pfc_pkg::ST_EMIT_B: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_let_nxt = sq_rsp.sq_q;
          out_end_nxt = 1'b1;
          state_nxt   = pfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfc_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfc_pkg::ST_IDLE;
      pend_valid_r <= 1'b0;
      pend_let_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_let_r   <= pend_let_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    b_let_r   <= b_let_nxt;
    pa_r      <= pa_nxt;
    na_r      <= na_nxt;
    nb_r      <= nb_nxt;
    sweep_r   <= sweep_nxt;
    out_let_r <= out_let_nxt;
    out_end_r <= out_end_nxt;
  end

  assign in_ch.ready          = (state_r == pfc_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cipher_letter = out_let_r;
  assign out_ch.pair_end      = out_end_r;

  // a pair is only worked on with a complete square
  `PFC_ASSERT_IMP(a_pair_needs_full_square, state_r == pfc_pkg::ST_POS_B, sq_rsp.full)
  // the fill sweep always ends with all cells taken
  `PFC_ASSERT_NXT(a_sweep_fills_square, sweep_last, sq_rsp.full)
  // the second letter of a pair is shown with pair_end set
  `PFC_ASSERT_NXT(a_second_letter_marked, (state_r == pfc_pkg::ST_EMIT_B) && out_load, out_ch.valid && out_ch.pair_end)

endmodule

### tb/playfair_digraph_cipher_core_tb.sv
// self-checking testbench for the playfair digraph cipher core
// needs pfc_pkg, pfc_in_if, pfc_out_if and the core; a directed table runs first,
// then random key and message sessions, checked against a local playfair predictor
module playfair_digraph_cipher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // opcodes the core must ignore
  localparam pfc_pkg::opcode_t OP_SPARE_LO = 3'd5;
  localparam pfc_pkg::opcode_t OP_SPARE_HI = 3'd7;

  // letters used by the directed rows
  localparam pfc_pkg::letter_t L_A      = pfc_pkg::letter_t'(0);
  localparam pfc_pkg::letter_t L_B      = pfc_pkg::letter_t'(1);
  localparam pfc_pkg::letter_t L_C      = pfc_pkg::letter_t'(2);
  localparam pfc_pkg::letter_t L_L      = pfc_pkg::letter_t'(11);
  localparam pfc_pkg::letter_t L_P      = pfc_pkg::letter_t'(15);
  localparam pfc_pkg::letter_t L_Z      = pfc_pkg::letter_t'(25);
  localparam pfc_pkg::letter_t L_BAD_LO = pfc_pkg::letter_t'(26);
  localparam pfc_pkg::letter_t L_BAD_HI = pfc_pkg::letter_t'(31);

  localparam int DirCount    = 27;
  localparam int RandomItems = 550;
  localparam int IdlePct     = 7;
  localparam int DrainCycles = 40;

  // one cipher letter as the core should hand it out
  typedef struct {
    pfc_pkg::letter_t cipher;
    logic             pair_end;
  } cipher_out_t;

  // one directed row; typed rows carry their expected letters, the rest use the predictor
  typedef struct packed {
    pfc_pkg::opcode_t op;
    pfc_pkg::letter_t ltr;
    logic             typed;
    logic [1:0]       n_out;
    pfc_pkg::letter_t c_first;
    pfc_pkg::letter_t c_second;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  playfair_digraph_cipher_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: the key square, where each letter sits, and the waiting letter
  pfc_pkg::letter_t              sq_cell [pfc_pkg::SquareCells];
  pfc_pkg::cell_t                cell_of_letter [pfc_pkg::AlphaSize];
  logic [pfc_pkg::AlphaSize-1:0] used_letters;
  int unsigned                   cells_filled;
  logic                          held_valid;
  pfc_pkg::letter_t              held_letter;

  // letters produced by the last predicted item
  cipher_out_t made [2];
  int          made_n;

  // cipher letters still owed by the core, oldest first
  cipher_out_t cipher_due [$];

  int errors;
  int sent_items;
  bit steady;

  task automatic report(input string what);
    errors++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // append one letter to the owed list
  function automatic void owe_letter(cipher_out_t c);
    cipher_due = {cipher_due, c};
  endfunction

  // new letter goes into the next free cell unless it is already in the square
  function automatic void put_in_square(pfc_pkg::letter_t l);
    if (l < pfc_pkg::AlphaSize && cells_filled < pfc_pkg::SquareCells && !used_letters[l]) begin
      sq_cell[cells_filled] = l;
      cell_of_letter[l]     = pfc_pkg::cell_t'(cells_filled);
      used_letters[l]       = 1'b1;
      cells_filled++;
    end
  endfunction

  // playfair rule on one digraph: column shifts down, row shifts right, else rectangle
  function automatic void encrypt_pair(pfc_pkg::letter_t a, pfc_pkg::letter_t b);
    int pa, pb, ra, ca, rb, cb, na, nb;
    pa = cell_of_letter[a];
    pb = cell_of_letter[b];
    ra = pa / 5;
    ca = pa % 5;
    rb = pb / 5;
    cb = pb % 5;
    if (ca == cb) begin
      na = ((ra + 1) % 5) * 5 + ca;
      nb = ((rb + 1) % 5) * 5 + cb;
    end else if (ra == rb) begin
      na = ra * 5 + (ca + 1) % 5;
      nb = rb * 5 + (cb + 1) % 5;
    end else begin
      na = ra * 5 + cb;
      nb = rb * 5 + ca;
    end
    made[0].cipher   = sq_cell[na];
    made[0].pair_end = 1'b0;
    made[1].cipher   = sq_cell[nb];
    made[1].pair_end = 1'b1;
    made_n = 2;
  endfunction

  // advance the predictor by one accepted item
  function automatic void encipher_item(pfc_pkg::opcode_t op, pfc_pkg::letter_t l);
    pfc_pkg::letter_t pad;
    made_n = 0;
    if (l == pfc_pkg::LetJ) l = pfc_pkg::LetI;
    case (op)
      pfc_pkg::OP_START_KEY: begin
        used_letters = '0;
        cells_filled = 0;
        held_valid   = 1'b0;
        held_letter  = '0;
      end
      pfc_pkg::OP_KEY_LETTER: begin
        put_in_square(l);
      end
      pfc_pkg::OP_FINISH_KEY: begin
        for (int i = 0; i < pfc_pkg::AlphaSize; i++)
          if (pfc_pkg::letter_t'(i) != pfc_pkg::LetJ) put_in_square(pfc_pkg::letter_t'(i));
      end
      pfc_pkg::OP_PLAIN: begin
        if (l < pfc_pkg::AlphaSize && cells_filled == pfc_pkg::SquareCells) begin
          if (!held_valid) begin
            held_letter = l;
            held_valid  = 1'b1;
          end else if (held_letter == l) begin
            // doubled letter: pad it and keep it waiting for the next one
            pad = (l == pfc_pkg::LetX) ? pfc_pkg::LetQ : pfc_pkg::LetX;
            encrypt_pair(l, pad);
          end else begin
            held_valid = 1'b0;
            encrypt_pair(held_letter, l);
          end
        end
      end
      pfc_pkg::OP_END_MSG: begin
        if (held_valid && cells_filled == pfc_pkg::SquareCells) begin
          held_valid = 1'b0;
          pad = (held_letter == pfc_pkg::LetX) ? pfc_pkg::LetQ : pfc_pkg::LetX;
          encrypt_pair(held_letter, pad);
        end
      end
      default: ;
    endcase
  endfunction

  // present one item, hold it until taken, then queue what it should produce
  task automatic send_item(input pfc_pkg::opcode_t op, input pfc_pkg::letter_t l,
                           input logic typed = 1'b0, input int n_typed = 0,
                           input pfc_pkg::letter_t c0 = '0,
                           input pfc_pkg::letter_t c1 = '0);
    cipher_out_t exp_letter;
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.letter    <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encipher_item(op, l);
    sent_items++;
    if (typed) begin
      if (n_typed == 2) begin
        exp_letter.cipher   = c0;
        exp_letter.pair_end = 1'b0;
        owe_letter(exp_letter);
        exp_letter.cipher   = c1;
        exp_letter.pair_end = 1'b1;
        owe_letter(exp_letter);
      end
    end else begin
      for (int k = 0; k < made_n; k++) owe_letter(made[k]);
    end
  endtask

  // result side: check each taken letter against the oldest one due, then pick next ready
  always @(posedge clk) begin : result_check
    cipher_out_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_due.size() == 0) begin
        report($sformatf("cipher letter %0d with nothing due", out_ch.cipher_letter));
      end else begin
        due = cipher_due.pop_front();
        if (out_ch.cipher_letter !== due.cipher)
          report($sformatf("cipher_letter got %0d want %0d",
                           out_ch.cipher_letter, due.cipher));
        if (out_ch.pair_end !== due.pair_end)
          report($sformatf("pair_end got %0b want %0b", out_ch.pair_end, due.pair_end));
      end
    end
    out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  initial begin : stimulus
    dir_row_t         dir_rows [DirCount];
    int               goal;
    int               quiet_from;
    int               key_len;
    int               msg_len;
    int               pick;
    pfc_pkg::letter_t prev;
    pfc_pkg::letter_t l;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= pfc_pkg::OP_START_KEY;
    in_ch.letter    <= '0;
    errors       = 0;
    sent_items   = 0;
    steady       = 1'b0;
    used_letters = '0;
    cells_filled = 0;
    held_valid   = 1'b0;
    held_letter  = '0;
    foreach (sq_cell[i]) sq_cell[i] = '0;
    foreach (cell_of_letter[i]) cell_of_letter[i] = '0;

    dir_rows = '{
      // nothing happens before a key is complete
      '{pfc_pkg::OP_PLAIN,      L_A,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_END_MSG,    L_A,           1'b1, 2'd0, L_A, L_A},
      // key: J folds onto I, repeats and bad letters are dropped
      '{pfc_pkg::OP_START_KEY,  L_Z,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_KEY_LETTER, L_P,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_KEY_LETTER, pfc_pkg::LetJ, 1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_KEY_LETTER, pfc_pkg::LetI, 1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_KEY_LETTER, L_BAD_HI,      1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_KEY_LETTER, L_Z,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_KEY_LETTER, L_A,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_FINISH_KEY, L_A,           1'b1, 2'd0, L_A, L_A},
      // square full: further key letters and spare opcodes do nothing
      '{pfc_pkg::OP_KEY_LETTER, L_B,           1'b1, 2'd0, L_A, L_A},
      '{OP_SPARE_HI,            L_BAD_HI,      1'b1, 2'd0, L_A, L_A},
      '{OP_SPARE_LO,            L_A,           1'b1, 2'd0, L_A, L_A},
      // doubled letter gets an X, then J pairs as I
      '{pfc_pkg::OP_PLAIN,      L_L,           1'b0, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_PLAIN,      L_L,           1'b0, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_PLAIN,      pfc_pkg::LetJ, 1'b0, 2'd0, L_A, L_A},
      // doubled X and X left over both pad with Q
      '{pfc_pkg::OP_PLAIN,      pfc_pkg::LetX, 1'b0, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_PLAIN,      pfc_pkg::LetX, 1'b0, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_END_MSG,    L_A,           1'b0, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_END_MSG,    L_A,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_PLAIN,      L_BAD_LO,      1'b1, 2'd0, L_A, L_A},
      // start key drops a waiting letter
      '{pfc_pkg::OP_PLAIN,      L_Z,           1'b0, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_START_KEY,  L_A,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_FINISH_KEY, L_A,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_END_MSG,    L_A,           1'b1, 2'd0, L_A, L_A},
      // plain alphabet square: A B share a row and shift to B C
      '{pfc_pkg::OP_PLAIN,      L_A,           1'b1, 2'd0, L_A, L_A},
      '{pfc_pkg::OP_PLAIN,      L_B,           1'b1, 2'd2, L_B, L_C}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].ltr, dir_rows[i].typed,
                int'(dir_rows[i].n_out), dir_rows[i].c_first, dir_rows[i].c_second);

    // random part: mostly whole key and message sessions, some loose noise
    goal       = sent_items + RandomItems;
    quiet_from = sent_items + 150;
    while (sent_items < goal) begin
      steady <= (sent_items >= quiet_from && sent_items < quiet_from + 100);
      if ($urandom_range(99) < 80) begin
        send_item(pfc_pkg::OP_START_KEY, pfc_pkg::letter_t'($urandom_range(0, 31)));
        // most keys short, a few long enough to fill the square on their own
        key_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        repeat (key_len) begin
          l = ($urandom_range(19) == 0) ? pfc_pkg::letter_t'($urandom_range(26, 31))
                                        : pfc_pkg::letter_t'($urandom_range(0, 25));
          send_item(pfc_pkg::OP_KEY_LETTER, l);
        end
        send_item(pfc_pkg::OP_FINISH_KEY, pfc_pkg::letter_t'($urandom_range(0, 31)));
        msg_len = $urandom_range(1, 40);
        prev    = pfc_pkg::letter_t'($urandom_range(0, 25));
        repeat (msg_len) begin
          pick = $urandom_range(99);
          if (pick < 3) begin
            send_item(pfc_pkg::opcode_t'($urandom_range(5, 7)),
                      pfc_pkg::letter_t'($urandom_range(0, 31)));
          end else if (pick < 5) begin
            send_item(pfc_pkg::OP_KEY_LETTER, pfc_pkg::letter_t'($urandom_range(0, 31)));
          end else begin
            // repeats and X are frequent to hit the padding rules
            if (pick < 25)      l = prev;
            else if (pick < 35) l = pfc_pkg::LetX;
            else if (pick < 39) l = pfc_pkg::letter_t'($urandom_range(26, 31));
            else                l = pfc_pkg::letter_t'($urandom_range(0, 25));
            send_item(pfc_pkg::OP_PLAIN, l);
            prev = l;
          end
        end
        if ($urandom_range(99) < 85)
          send_item(pfc_pkg::OP_END_MSG, pfc_pkg::letter_t'($urandom_range(0, 31)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(pfc_pkg::opcode_t'($urandom_range(0, 7)),
                    pfc_pkg::letter_t'($urandom_range(0, 31)));
      end
    end
    in_ch.valid <= 1'b0;
    steady      <= 1'b0;

    // drain the letters still owed, then watch a while for strays
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && cipher_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
